// ===== design/nhr_pkg.sv =====
`timescale 1ns / 1ps
package nhr_pkg;

    localparam int OP_W    = 3;
    localparam int ADDR_W  = 64;
    localparam int SEQ_W   = 32;
    localparam int TIME_W  = 48;
    localparam int STAT_W  = 2;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_BUSY = 3'd2;
    localparam logic [OP_W-1:0] OP_HAND_OFF = 3'd3;
    localparam logic [OP_W-1:0] OP_HAND_IN  = 3'd4;
    localparam logic [OP_W-1:0] OP_LOOK_UP  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_BUSY      = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address_high;
        logic [ADDR_W-1:0] address_low;
        logic [SEQ_W-1:0]  adv_seqno;
        logic [SEQ_W-1:0]  hop_seqno;
        logic              busy_flag;
        logic [TIME_W-1:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [INDEX_W-1:0] slot_index;
        logic [SEQ_W-1:0]   adv_seqno_out;
        logic [SEQ_W-1:0]   hop_seqno_out;
        logic               busy_out;
        logic [TIME_W-1:0]  last_seen_out;
        logic [COUNT_W-1:0] valid_count;
    } t_res;

    // One slot row as kept in the memory.
    typedef struct packed {
        logic [ADDR_W-1:0] key_upper;
        logic [ADDR_W-1:0] key_lower;
        logic [SEQ_W-1:0]  route_seq;
        logic [SEQ_W-1:0]  hop_seq;
        logic [TIME_W-1:0] seen_time;
    } t_row;

endpackage

// ===== design/nhr_req_if.sv =====
`timescale 1ns / 1ps
interface nhr_req_if
    import nhr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address_high;
    logic [ADDR_W-1:0] address_low;
    logic [SEQ_W-1:0]  adv_seqno;
    logic [SEQ_W-1:0]  hop_seqno;
    logic              busy_flag;
    logic [TIME_W-1:0] now_ms;

    modport source (
        output valid, operation, address_high, address_low, adv_seqno,
               hop_seqno, busy_flag, now_ms,
        input  ready
    );
    modport sink (
        input  valid, operation, address_high, address_low, adv_seqno,
               hop_seqno, busy_flag, now_ms,
        output ready
    );
endinterface

// ===== design/nhr_rsp_if.sv =====
`timescale 1ns / 1ps
interface nhr_rsp_if
    import nhr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] slot_index;
    logic [SEQ_W-1:0]   adv_seqno_out;
    logic [SEQ_W-1:0]   hop_seqno_out;
    logic               busy_out;
    logic [TIME_W-1:0]  last_seen_out;
    logic [COUNT_W-1:0] valid_count;

    modport source (
        output valid, status, slot_index, adv_seqno_out, hop_seqno_out,
               busy_out, last_seen_out, valid_count,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, adv_seqno_out, hop_seqno_out,
               busy_out, last_seen_out, valid_count,
        output ready
    );
endinterface

// ===== design/nhr_mem.sv =====
`timescale 1ns / 1ps
module nhr_mem
    import nhr_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_row          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_row          o_rdata
);

    t_row r_mem [DEPTH];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/nhr_seq.sv =====
`timescale 1ns / 1ps
module nhr_seq
    import nhr_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_req          i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_res          o_res,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output t_row          o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  t_row          i_mem_rdata
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    t_state          r_state;
    t_req            r_req;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_busy;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_addr;
    logic            r_issue;
    logic            r_cmp_vld;
    logic [AW-1:0]   r_cmp_idx;
    logic            r_found;
    logic [AW-1:0]   r_hit_idx;
    t_row            r_hit_row;
    logic            r_free_found;
    logic [AW-1:0]   r_free_idx;

    logic            hit;
    logic            n_set_valid;
    logic            n_clr_valid;
    logic            n_set_busy;
    logic            n_busy_val;
    logic [AW-1:0]   n_slot;
    logic [CW-1:0]   n_cnt;
    logic [STAT_W-1:0] n_status;
    logic [SEQ_W-1:0]  n_ro;
    logic [SEQ_W-1:0]  n_po;
    logic              n_bo;
    logic [TIME_W-1:0] n_lso;
    logic [AW+INDEX_W-1:0] idx_wide;
    logic [CW+COUNT_W-1:0] cnt_wide;

    assign hit = r_cmp_vld && r_valid[r_cmp_idx]
              && (i_mem_rdata.key_upper == r_req.address_high)
              && (i_mem_rdata.key_lower == r_req.address_low);

    assign o_mem_raddr = r_addr;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EXEC);

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_free_idx;
        o_mem_wdata = '{key_upper: r_req.address_high, key_lower: r_req.address_low,
                        route_seq: r_req.adv_seqno, hop_seq: r_req.hop_seqno,
                        seen_time: r_req.now_ms};
        n_set_valid = 1'b0;
        n_clr_valid = 1'b0;
        n_set_busy  = 1'b0;
        n_busy_val  = 1'b0;
        n_slot      = '0;
        n_cnt       = r_cnt;
        n_status    = ST_OK;
        n_ro        = '0;
        n_po        = '0;
        n_bo        = 1'b0;
        n_lso       = '0;
        case (r_req.operation)
            OP_REGISTER: begin
                if (r_found) begin
                    // refresh in place, busy mark kept
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_hit_idx;
                    n_slot      = r_hit_idx;
                end else if (r_free_found) begin
                    o_mem_we    = 1'b1;
                    n_slot      = r_free_idx;
                    n_set_valid = 1'b1;
                    n_set_busy  = 1'b1;
                    n_cnt       = r_cnt + CW'(1);
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (r_found) begin
                    n_slot      = r_hit_idx;
                    n_clr_valid = 1'b1;
                    n_cnt       = r_cnt - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_SET_BUSY: begin
                if (r_found) begin
                    n_slot     = r_hit_idx;
                    n_set_busy = 1'b1;
                    n_busy_val = r_req.busy_flag;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_HAND_OFF: begin
                if (!r_found) begin
                    n_status = ST_NOT_FOUND;
                end else if (r_busy[r_hit_idx]) begin
                    n_status = ST_BUSY;
                    n_slot   = r_hit_idx;
                end else begin
                    n_slot      = r_hit_idx;
                    n_ro        = r_hit_row.route_seq;
                    n_po        = r_hit_row.hop_seq;
                    n_clr_valid = 1'b1;
                    n_cnt       = r_cnt - CW'(1);
                end
            end
            OP_HAND_IN: begin
                if (r_free_found) begin
                    o_mem_we              = 1'b1;
                    o_mem_wdata.route_seq = r_req.adv_seqno + SEQ_W'(1);
                    o_mem_wdata.hop_seq   = r_req.hop_seqno + SEQ_W'(1);
                    n_slot                = r_free_idx;
                    n_set_valid           = 1'b1;
                    n_set_busy            = 1'b1;
                    n_cnt                 = r_cnt + CW'(1);
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_LOOK_UP: begin
                if (r_found) begin
                    n_slot = r_hit_idx;
                    n_ro   = r_hit_row.route_seq;
                    n_po   = r_hit_row.hop_seq;
                    n_bo   = r_busy[r_hit_idx];
                    n_lso  = r_hit_row.seen_time;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        // hold the write until the result can leave
        o_mem_we = o_mem_we && (r_state == S_EXEC) && i_res_ready;
    end

    assign idx_wide = {{INDEX_W{1'b0}}, n_slot};
    assign cnt_wide = {{COUNT_W{1'b0}}, n_cnt};

    always_comb begin
        o_res.status        = n_status;
        o_res.slot_index    = idx_wide[INDEX_W-1:0];
        o_res.adv_seqno_out = n_ro;
        o_res.hop_seqno_out = n_po;
        o_res.busy_out      = n_bo;
        o_res.last_seen_out = n_lso;
        o_res.valid_count   = cnt_wide[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_busy    <= '0;
            r_cnt     <= '0;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req        <= i_req;
                        r_addr       <= '0;
                        r_issue      <= 1'b1;
                        r_cmp_vld    <= 1'b0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (!r_free_found && !r_valid[r_addr]) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_addr;
                        end
                        if (r_addr == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + AW'(1);
                        end
                    end
                    r_cmp_vld <= r_issue;
                    r_cmp_idx <= r_addr;
                    if (hit && !r_found) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                        r_hit_row <= i_mem_rdata;
                    end
                    if (r_cmp_vld && r_cmp_idx == LAST) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (i_res_ready) begin
                        if (n_set_valid) begin
                            r_valid[n_slot] <= 1'b1;
                        end
                        if (n_clr_valid) begin
                            r_valid[n_slot] <= 1'b0;
                        end
                        if (n_set_busy) begin
                            r_busy[n_slot] <= n_busy_val;
                        end
                        r_cnt   <= n_cnt;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_cnt))
        else $error("valid count out of step with valid bits");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOTS))
        else $error("valid count above slot count");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_SCAN && r_issue && r_addr == '0))
        else $error("scan did not start from slot zero");

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) |=> (r_state == S_IDLE))
        else $error("sequencer stuck after result transfer");
`endif

endmodule

// ===== design/node_handoff_registry_top.sv =====
`timescale 1ns / 1ps
// Node registry of SLOTS slots keyed by a 128-bit address. Each operation
// scans every slot through a registered-read memory port, one slot per
// cycle, then commits its write and result once the result can leave. A new
// item is taken only after the previous one has committed, as its scan holds
// the single memory read port. The result sits in an output register,
// so the next item is taken while the previous result still waits. Valid and
// busy marks are flip-flops cleared at reset; the slot rows need no clearing.
module node_handoff_registry_top
    import nhr_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nhr_req_if.sink   i_req,
    nhr_rsp_if.source o_rsp
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_req          req;
    t_res          res;
    logic          res_valid;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_row          mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_row          mem_rdata;
    logic          r_out_valid;
    t_res          r_out;

    always_comb begin
        req.operation    = i_req.operation;
        req.address_high = i_req.address_high;
        req.address_low  = i_req.address_low;
        req.adv_seqno    = i_req.adv_seqno;
        req.hop_seqno    = i_req.hop_seqno;
        req.busy_flag    = i_req.busy_flag;
        req.now_ms       = i_req.now_ms;
    end

    nhr_seq #(.SLOTS(SLOTS)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    nhr_mem #(.DEPTH(SLOTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // load when empty or when the current result transfers this cycle
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
            r_out       <= res;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.slot_index    = r_out.slot_index;
    assign o_rsp.adv_seqno_out = r_out.adv_seqno_out;
    assign o_rsp.hop_seqno_out = r_out.hop_seqno_out;
    assign o_rsp.busy_out      = r_out.busy_out;
    assign o_rsp.last_seen_out = r_out.last_seen_out;
    assign o_rsp.valid_count   = r_out.valid_count;

endmodule
